/* rtl/websocket_frame_deframer_unit_assert.svh */
// assertion macros for the websocket frame deframer
// used by the top level only, no other dependencies
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication
`define WSD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/wsd_pkg.sv */
// shared types and constants for the websocket frame deframer
// no dependencies
`timescale 1ns / 1ps

package wsd_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned LEN_W     = 63;
   localparam int unsigned KEY_W     = 32;
   localparam int unsigned RSP_TDATA_W = 80;

   localparam logic       KIND_HEADER  = 1'b0;
   localparam logic       KIND_PAYLOAD = 1'b1;

   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   localparam logic [2:0] EXT16_LAST_IDX = 3'd1;
   localparam logic [2:0] EXT64_LAST_IDX = 3'd7;
   localparam logic [2:0] KEY_LAST_IDX   = 3'd3;

   typedef enum logic [2:0] {
      PH_HDR0    = 3'd0,
      PH_HDR1    = 3'd1,
      PH_EXT16   = 3'd2,
      PH_EXT64   = 3'd3,
      PH_KEY     = 3'd4,
      PH_PAYLOAD = 3'd5
   } wsd_phase_type;

   typedef struct packed {
      logic              kind;
      logic              fin;
      logic [3:0]        opcode;
      logic              masked;
      logic [LEN_W-1:0]  frame_length;
      logic [BYTE_W-1:0] payload_byte;
      logic              last;
   } wsd_result_type;

endpackage

/* rtl/websocket_frame_deframer_unit.sv */
// websocket frame deframer: byte stream in, frame headers and unmasked payload out
// channels: req_* carries one raw byte per transfer; rsp_* carries one result per transfer
// rsp_tuser is the result kind: 0 = decoded frame header, 1 = unmasked payload byte
// rsp_tlast marks the final result of a frame (the header itself for an empty frame)
// a header result follows the second header byte, the last extended length byte or
// the last masking key byte, whichever ends the header; other header bytes give nothing
// payload results carry fin, opcode, mask flag and length of their frame again
// an accepted byte is held in the input register, then its result in the result register
// throughput: one byte per cycle unless rsp_tready stalls, set by the combinational parser
// step between the input register and the result register
// reset (synchronous, active high) empties both registers and waits for a first header byte
// when rsp_tready is low the result holds, one more byte waits in the input register,
// then req_tready drops until the result is taken
// depends on wsd_pkg, wsd_in_stage, wsd_parser and the assertion macro header
`timescale 1ns / 1ps

`include "websocket_frame_deframer_unit_assert.svh"

module websocket_frame_deframer_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [wsd_pkg::BYTE_W-1:0]      req_tdata,   // [7:0] stream_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [wsd_pkg::RSP_TDATA_W-1:0] rsp_tdata,   // [0] fin, [4:1] opcode,
                                                        // [5] masked, [68:6] frame_length,
                                                        // [76:69] payload_byte, [79:77] zero
   output logic                            rsp_tuser,   // [0] kind
   output logic                            rsp_tlast    // last
);
   import wsd_pkg::*;

   logic              take;
   logic              stage_valid;
   logic [BYTE_W-1:0] stage_byte;
   wsd_result_type    result;

   wsd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .take        (take),
      .stage_valid (stage_valid),
      .stage_byte  (stage_byte)
   );

   wsd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage_byte  (stage_byte),
      .take        (take),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_result  (result)
   );

   assign rsp_tdata = {3'b000, result.payload_byte, result.frame_length,
                       result.masked, result.opcode, result.fin};
   assign rsp_tuser = result.kind;
   assign rsp_tlast = result.last;

   `WSD_ASSERT_NOW(a_empty_header_last, clock, reset,
      rsp_tvalid && rsp_tuser == KIND_HEADER && rsp_tlast,
      rsp_tdata[68:6] == '0, "last header result with nonzero frame length")
   `WSD_ASSERT_NOW(a_header_no_payload, clock, reset,
      rsp_tvalid && rsp_tuser == KIND_HEADER,
      rsp_tdata[76:69] == '0, "header result with nonzero payload byte")
   `WSD_ASSERT_NOW(a_payload_length, clock, reset,
      rsp_tvalid && rsp_tuser == KIND_PAYLOAD,
      rsp_tdata[68:6] != '0, "payload result in a frame of zero length")
   `WSD_ASSERT_NEXT(a_stall_blocks, clock, reset,
      rsp_tvalid && !rsp_tready && stage_valid,
      !req_tready || rsp_tvalid, "input taken while a full pipe is stalled")

endmodule

/* rtl/wsd_in_stage.sv */
// input register stage: holds one accepted byte until the parser takes it
// depends on wsd_pkg
`timescale 1ns / 1ps

module wsd_in_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [wsd_pkg::BYTE_W-1:0] req_tdata,
   input  logic                       take,
   output logic                       stage_valid,
   output logic [wsd_pkg::BYTE_W-1:0] stage_byte
);
   import wsd_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              accept;

   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (accept) begin
         valid_in = 1'b1;
         byte_in  = req_tdata;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign stage_valid = valid_ff;
   assign stage_byte  = byte_ff;

endmodule

/* rtl/wsd_parser.sv */
// frame parser: header state, length and key assembly, unmasking, result register
// depends on wsd_pkg
`timescale 1ns / 1ps

module wsd_parser (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       stage_valid,
   input  logic [wsd_pkg::BYTE_W-1:0] stage_byte,
   output logic                       take,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output wsd_pkg::wsd_result_type    rsp_result
);
   import wsd_pkg::*;

   wsd_phase_type     phase_ff, phase_in;
   logic [2:0]        count_ff, count_in;
   logic [LEN_W-1:0]  length_ff, length_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic              mask_ff, mask_in;
   logic              fin_ff, fin_in;
   logic [3:0]        opcode_ff, opcode_in;
   logic [LEN_W-1:0]  remaining_ff, remaining_in;
   logic [1:0]        key_idx_ff, key_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   wsd_result_type    result_ff, result_in;

   always_comb begin
      logic              emit;
      logic              hdr;
      logic              len_done;
      logic [6:0]        len7;
      logic [LEN_W-1:0]  rem_dec;
      logic [BYTE_W-1:0] key_byte;
      logic [LEN_W-1:0]  shifted;

      phase_in     = phase_ff;
      count_in     = count_ff;
      length_in    = length_ff;
      key_in       = key_ff;
      mask_in      = mask_ff;
      fin_in       = fin_ff;
      opcode_in    = opcode_ff;
      remaining_in = remaining_ff;
      key_idx_in   = key_idx_ff;
      emit         = 1'b0;
      hdr          = 1'b0;
      len_done     = 1'b0;
      len7         = stage_byte[6:0];
      shifted      = {length_ff[LEN_W-1-BYTE_W:0], stage_byte};
      rem_dec      = (remaining_ff == '0) ? '0 : remaining_ff - LEN_W'(1);
      key_byte     = key_ff[(KEY_W-1) - BYTE_W*key_idx_ff -: BYTE_W];
      result_in    = result_ff;

      take = stage_valid && (!rsp_valid_ff || rsp_ready);

      if (take) begin
         unique case (phase_ff)
            PH_HDR1: begin
               mask_in    = stage_byte[7];
               key_in     = '0;
               key_idx_in = '0;
               count_in   = '0;
               length_in  = '0;
               if (len7 == LEN7_EXT16) begin
                  phase_in = PH_EXT16;
               end else if (len7 == LEN7_EXT64) begin
                  phase_in = PH_EXT64;
               end else begin
                  length_in = LEN_W'(len7);
                  len_done  = 1'b1;
               end
            end
            PH_EXT16: begin
               length_in = shifted;
               if (count_ff >= EXT16_LAST_IDX) begin
                  len_done = 1'b1;
               end else begin
                  count_in = count_ff + 3'd1;
               end
            end
            PH_EXT64: begin
               length_in = shifted;
               if (count_ff >= EXT64_LAST_IDX) begin
                  len_done = 1'b1;
               end else begin
                  count_in = count_ff + 3'd1;
               end
            end
            PH_KEY: begin
               key_in = {key_ff[KEY_W-1-BYTE_W:0], stage_byte};
               if (count_ff >= KEY_LAST_IDX) begin
                  count_in = '0;
                  hdr      = 1'b1;
               end else begin
                  count_in = count_ff + 3'd1;
               end
            end
            PH_PAYLOAD: begin
               key_idx_in   = key_idx_ff + 2'd1;
               remaining_in = rem_dec;
               emit         = 1'b1;
               result_in.kind         = KIND_PAYLOAD;
               result_in.fin          = fin_ff;
               result_in.opcode       = opcode_ff;
               result_in.masked       = mask_ff;
               result_in.frame_length = length_ff;
               result_in.payload_byte = stage_byte ^ key_byte;
               result_in.last         = (rem_dec == '0);
               if (rem_dec == '0) begin
                  phase_in = PH_HDR0;
               end
            end
            default: begin
               fin_in    = stage_byte[7];
               opcode_in = stage_byte[3:0];
               phase_in  = PH_HDR1;
            end
         endcase

         if (len_done) begin
            count_in = '0;
            if (mask_in) begin
               phase_in = PH_KEY;
            end else begin
               hdr = 1'b1;
            end
         end

         if (hdr) begin
            emit         = 1'b1;
            remaining_in = length_in;
            key_idx_in   = '0;
            phase_in     = (length_in != '0) ? PH_PAYLOAD : PH_HDR0;
            result_in.kind         = KIND_HEADER;
            result_in.fin          = fin_in;
            result_in.opcode       = opcode_in;
            result_in.masked       = mask_in;
            result_in.frame_length = length_in;
            result_in.payload_byte = '0;
            result_in.last         = (length_in == '0);
         end
      end

      if (take) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR0;
         count_ff     <= '0;
         length_ff    <= '0;
         key_ff       <= '0;
         mask_ff      <= 1'b0;
         fin_ff       <= 1'b0;
         opcode_ff    <= '0;
         remaining_ff <= '0;
         key_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         length_ff    <= length_in;
         key_ff       <= key_in;
         mask_ff      <= mask_in;
         fin_ff       <= fin_in;
         opcode_ff    <= opcode_in;
         remaining_ff <= remaining_in;
         key_idx_ff   <= key_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

endmodule
